/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; each expands to one labeled
// concurrent assertion with a disable iff on reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/dahdsr_pkg.sv */
// ---------------------------------------------------------------------------
// dahdsr_pkg
// Shared constants, register map and control structs of the DAHDSR envelope.
// ---------------------------------------------------------------------------
package dahdsr_pkg;

  // voice count and gate-rise ramp-down length
  localparam int VOICES       = 16;
  localparam int RESPONSE_LEN = 256;

  // field widths
  localparam int VOICE_W = 4;
  localparam int SMP_W   = 16;
  localparam int LVL_W   = 25;
  localparam int OFS_W   = 26;
  localparam int BND_W   = 24;
  localparam int RATE_W  = 32;
  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;

  // APB
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // fixed-point constants
  localparam logic [LVL_W-1:0]        FULL_SCALE = LVL_W'(24'hFFFFFF) + LVL_W'(1);
  localparam logic signed [SMP_W-1:0] HALF_Q15   = 16'sd16384;
  localparam logic signed [OFS_W-1:0] OFS_MAX    = 26'sd33554431;
  localparam logic signed [OFS_W-1:0] RESP_OFS   = OFS_W'(-RESPONSE_LEN);

  // register indexes
  localparam logic [2:0] REG_DELAY_END     = 3'd0;
  localparam logic [2:0] REG_ATTACK_END    = 3'd1;
  localparam logic [2:0] REG_HOLD_END      = 3'd2;
  localparam logic [2:0] REG_DECAY_END     = 3'd3;
  localparam logic [2:0] REG_ATTACK_STEP   = 3'd4;
  localparam logic [2:0] REG_DECAY_STEP    = 3'd5;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd6;
  localparam logic [2:0] REG_RELEASE_RATE  = 3'd7;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [BND_W-1:0]  delay_end;
    logic [BND_W-1:0]  attack_end;
    logic [BND_W-1:0]  hold_end;
    logic [BND_W-1:0]  decay_end;
    logic [LVL_W-1:0]  attack_step;
    logic [LVL_W-1:0]  decay_step;
    logic [LVL_W-1:0]  sustain_level;
    logic [RATE_W-1:0] release_rate;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture accepted item
    logic prep;   // read voice state, apply gate/retrigger edges
    logic mul;    // release product
    logic fire;   // write back and load output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/dahdsr_in_if.sv */
// ---------------------------------------------------------------------------
// dahdsr_in_if
// Input channel: one audio sample pair for one voice per item.
// ---------------------------------------------------------------------------
interface dahdsr_in_if;
  import dahdsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VOICE_W-1:0]       voice;
  logic signed [SMP_W-1:0]  gate_sample;
  logic signed [SMP_W-1:0]  retrigger_sample;

  modport source (output valid, voice, gate_sample, retrigger_sample, input ready);
  modport sink   (input valid, voice, gate_sample, retrigger_sample, output ready);
endinterface

/* rtl/dahdsr_out_if.sv */
// ---------------------------------------------------------------------------
// dahdsr_out_if
// Output channel: envelope level and its negation for one voice per item.
// ---------------------------------------------------------------------------
interface dahdsr_out_if;
  import dahdsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VOICE_W-1:0]       voice_out;
  logic [LVL_W-1:0]         level_out;
  logic signed [LVL_W-1:0]  inverse_out;

  modport source (output valid, voice_out, level_out, inverse_out, input ready);
  modport sink   (input valid, voice_out, level_out, inverse_out, output ready);
endinterface

/* rtl/dahdsr_envelope_generator_core.sv */
// ---------------------------------------------------------------------------
// dahdsr_envelope_generator_core
// Polyphonic delay-attack-hold-decay-sustain-release envelope generator.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      voice, gate_sample, retrigger_sample
//   out_ch   out  valid/ready      voice_out, level_out, inverse_out
//   apb      in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item at a time: accept, prepare, a divide when a retrigger rise runs the
// bit-serial divider (25 quotient bits, one a cycle), multiply, write back.
// Synchronous reset clears all voice state and the sequencer.
// A full output register holds write-back until the sink takes the result;
// a new item is taken while the previous result still waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dahdsr_envelope_generator_core import dahdsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dahdsr_in_if.sink         in_ch,
  dahdsr_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t sts;

  assign pready = 1'b1;

  // configuration registers
  dahdsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer
  dahdsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  dahdsr_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .voice            (in_ch.voice),
    .gate_sample      (in_ch.gate_sample),
    .retrigger_sample (in_ch.retrigger_sample),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .voice_out        (out_ch.voice_out),
    .level_out        (out_ch.level_out),
    .inverse_out      (out_ch.inverse_out)
  );

  // one item in flight: no accept right after an accept
  `ASSERT_NXT(a_one_in_flight, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // results appear only from a write-back
  `ASSERT_IMP(a_out_from_fire, clk, rst, $rose(out_ch.valid), $past(cmd.fire))
  // sequencer returns to idle after write-back
  `ASSERT_NXT(a_fire_to_idle, clk, rst, cmd.fire, in_ch.ready)

endmodule

/* rtl/dahdsr_regs.sv */
// ---------------------------------------------------------------------------
// dahdsr_regs
// APB configuration registers: stage boundaries, steps, sustain, release.
// ---------------------------------------------------------------------------
module dahdsr_regs import dahdsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_end     <= BND_W'(0);
      cfg.attack_end    <= BND_W'(2205);
      cfg.hold_end      <= BND_W'(3087);
      cfg.decay_end     <= BND_W'(7497);
      cfg.attack_step   <= LVL_W'(7608);
      cfg.decay_step    <= LVL_W'(1141);
      cfg.sustain_level <= LVL_W'(11744051);
      cfg.release_rate  <= RATE_W'(7608);
    end else if (wr_en) begin
      case (idx)
        REG_DELAY_END:     cfg.delay_end     <= pwdata[BND_W-1:0];
        REG_ATTACK_END:    cfg.attack_end    <= pwdata[BND_W-1:0];
        REG_HOLD_END:      cfg.hold_end      <= pwdata[BND_W-1:0];
        REG_DECAY_END:     cfg.decay_end     <= pwdata[BND_W-1:0];
        REG_ATTACK_STEP:   cfg.attack_step   <= pwdata[LVL_W-1:0];
        REG_DECAY_STEP:    cfg.decay_step    <= pwdata[LVL_W-1:0];
        REG_SUSTAIN_LEVEL: cfg.sustain_level <= pwdata[LVL_W-1:0];
        REG_RELEASE_RATE:  cfg.release_rate  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_DELAY_END:     prdata = DATA_W'(cfg.delay_end);
      REG_ATTACK_END:    prdata = DATA_W'(cfg.attack_end);
      REG_HOLD_END:      prdata = DATA_W'(cfg.hold_end);
      REG_DECAY_END:     prdata = DATA_W'(cfg.decay_end);
      REG_ATTACK_STEP:   prdata = DATA_W'(cfg.attack_step);
      REG_DECAY_STEP:    prdata = DATA_W'(cfg.decay_step);
      REG_SUSTAIN_LEVEL: prdata = DATA_W'(cfg.sustain_level);
      REG_RELEASE_RATE:  prdata = cfg.release_rate;
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/dahdsr_div.sv */
// ---------------------------------------------------------------------------
// dahdsr_div
// Restoring divider, one quotient bit per cycle, for the retrigger offset.
// ---------------------------------------------------------------------------
module dahdsr_div import dahdsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LVL_W-1:0] num,
  input  logic [LVL_W-1:0] den,
  output logic             done,
  output logic [LVL_W-1:0] quo
);

  localparam int CNT_W = $clog2(LVL_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LVL_W-1:0] rem;
  logic [LVL_W-1:0] den_q;
  logic [LVL_W:0]   trial;
  logic             take;

  // shift in the next numerator bit and try a subtract
  assign trial = {rem, quo[LVL_W-1]};
  assign take  = trial >= {1'b0, den_q};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(LVL_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= take ? LVL_W'(trial - {1'b0, den_q}) : trial[LVL_W-1:0];
      quo <= {quo[LVL_W-2:0], take};
    end
  end

endmodule

/* rtl/dahdsr_dp.sv */
// ---------------------------------------------------------------------------
// dahdsr_dp
// Datapath: per-voice state, edge detection, stage selection, level update
// and the output register.
// ---------------------------------------------------------------------------
module dahdsr_dp import dahdsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  dp_cmd_t                  cmd,
  output dp_status_t               sts,
  input  logic [VOICE_W-1:0]       voice,
  input  logic signed [SMP_W-1:0]  gate_sample,
  input  logic signed [SMP_W-1:0]  retrigger_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VOICE_W-1:0]       voice_out,
  output logic [LVL_W-1:0]         level_out,
  output logic signed [LVL_W-1:0]  inverse_out
);

  localparam logic [2:0] STG_RAMP  = 3'd0;
  localparam logic [2:0] STG_DELAY = 3'd1;
  localparam logic [2:0] STG_ATK   = 3'd2;
  localparam logic [2:0] STG_HOLD  = 3'd3;
  localparam logic [2:0] STG_DECAY = 3'd4;
  localparam logic [2:0] STG_SUS   = 3'd5;

  // per-voice state
  logic                    gate_on       [VOICES];
  logic                    retrig_on     [VOICES];
  logic [LVL_W-1:0]        env_level     [VOICES];
  logic signed [OFS_W-1:0] stage_offset  [VOICES];
  logic [LVL_W-1:0]        fall_step     [VOICES];
  logic [LVL_W-1:0]        release_start [VOICES];

  // captured item
  logic [VOICE_W-1:0] voice_q;
  logic               inrange_q;
  logic               gate_hi, gate_lo, ret_hi, ret_lo;
  logic [VIDX_W-1:0]  vidx;

  // working copy of the voice
  logic                    w_gate, w_retrig;
  logic [LVL_W-1:0]        w_level, w_fall, w_rstart;
  logic signed [OFS_W-1:0] w_ofs;
  logic [56:0]             prod;

  // prep-stage combinational values
  logic                    g_rise, g_fall, r_rise, r_fall;
  logic                    p_gate, p_retrig;
  logic [LVL_W-1:0]        p_level, p_fall, p_rstart;
  logic signed [OFS_W-1:0] p_ofs;

  // update-stage combinational values
  logic [2:0]              stage;
  logic [LVL_W:0]          atk_sum;
  logic [32:0]             rel_dec;
  logic [LVL_W-1:0]        e_new;
  logic signed [OFS_W-1:0] ofs_new;

  logic             div_done;
  logic [LVL_W-1:0] div_quo;

  assign vidx = voice_q[VIDX_W-1:0];

  // capture item and threshold the samples
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      voice_q   <= voice;
      inrange_q <= int'(voice) < VOICES;
      gate_hi   <= gate_sample > HALF_Q15;
      gate_lo   <= gate_sample < HALF_Q15;
      ret_hi    <= retrigger_sample > HALF_Q15;
      ret_lo    <= retrigger_sample < HALF_Q15;
    end
  end

  // gate and retrigger edges on the stored voice state
  always_comb begin
    p_level  = env_level[vidx];
    p_gate   = gate_on[vidx];
    p_retrig = retrig_on[vidx];
    p_ofs    = stage_offset[vidx];
    p_fall   = fall_step[vidx];
    p_rstart = release_start[vidx];
    g_rise   = !p_gate && gate_hi;
    g_fall   = p_gate && gate_lo;
    r_rise   = !p_retrig && ret_hi;
    r_fall   = p_retrig && ret_lo;
    if (g_rise) begin
      p_gate = 1'b1;
      if (p_level != '0) begin
        p_ofs  = RESP_OFS;
        p_fall = LVL_W'(p_level / RESPONSE_LEN);
      end else begin
        p_ofs = '0;
      end
    end
    if (g_fall) begin
      p_gate   = 1'b0;
      p_rstart = p_level;
    end
    if (r_rise) begin
      p_retrig = 1'b1;
      p_ofs    = '0;   // replaced by the quotient when a divide runs
    end
    if (r_fall) begin
      p_retrig = 1'b0;
    end
  end

  assign sts.need_div = inrange_q && r_rise && (p_level != '0) && (cfg.attack_step != '0);

  // offset = level / attack_step on a retrigger rise
  dahdsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.prep && sts.need_div),
    .num   (p_level),
    .den   (cfg.attack_step),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sts.div_done = div_done;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      w_gate   <= p_gate;
      w_retrig <= p_retrig;
      w_level  <= p_level;
      w_ofs    <= p_ofs;
      w_fall   <= p_fall;
      w_rstart <= p_rstart;
    end else if (div_done) begin
      w_ofs <= $signed({1'b0, div_quo});
    end
    if (cmd.mul) begin
      prod <= w_rstart * cfg.release_rate;
    end
  end

  // stage choice: later boundaries override earlier ones
  always_comb begin
    stage = STG_DELAY;
    if (w_ofs < 0) stage = STG_RAMP;
    if (w_ofs >= $signed({2'b00, cfg.delay_end}))  stage = STG_ATK;
    if (w_ofs >= $signed({2'b00, cfg.attack_end})) stage = STG_HOLD;
    if (w_ofs >= $signed({2'b00, cfg.hold_end}))   stage = STG_DECAY;
    if (w_ofs >= $signed({2'b00, cfg.decay_end}))  stage = STG_SUS;
  end

  assign atk_sum = {1'b0, w_level} + {1'b0, cfg.attack_step};
  assign rel_dec = prod[56:24];

  // level update
  always_comb begin
    ofs_new = w_ofs;
    if (w_gate) begin
      case (stage)
        STG_RAMP:  e_new = (w_level > w_fall) ? w_level - w_fall : '0;
        STG_ATK:   e_new = (atk_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : atk_sum[LVL_W-1:0];
        STG_HOLD:  e_new = FULL_SCALE;
        STG_DECAY: e_new = (w_level > cfg.decay_step) ? w_level - cfg.decay_step : '0;
        STG_SUS:   e_new = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;
        default:   e_new = '0;
      endcase
      if (w_ofs < OFS_MAX) ofs_new = w_ofs + OFS_W'(1);
    end else if (cfg.release_rate == '0) begin
      e_new = '0;
    end else begin
      e_new = ({8'd0, w_level} > rel_dec) ? w_level - rel_dec[LVL_W-1:0] : '0;
    end
    if (e_new > FULL_SCALE) e_new = FULL_SCALE;
  end

  // voice state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        gate_on[i]       <= 1'b0;
        retrig_on[i]     <= 1'b0;
        env_level[i]     <= '0;
        stage_offset[i]  <= '0;
        fall_step[i]     <= '0;
        release_start[i] <= '0;
      end
    end else if (cmd.fire && inrange_q) begin
      gate_on[vidx]       <= w_gate;
      retrig_on[vidx]     <= w_retrig;
      env_level[vidx]     <= e_new;
      stage_offset[vidx]  <= ofs_new;
      fall_step[vidx]     <= w_fall;
      release_start[vidx] <= w_rstart;
    end
  end

  // output register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      voice_out   <= voice_q;
      level_out   <= inrange_q ? e_new : '0;
      inverse_out <= inrange_q ? $signed(LVL_W'(0) - e_new) : '0;
    end
  end

endmodule

/* rtl/dahdsr_ctrl.sv */
// ---------------------------------------------------------------------------
// dahdsr_ctrl
// Sequencer: accept, prepare, optional divide, multiply, write back.
// ---------------------------------------------------------------------------
module dahdsr_ctrl import dahdsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == ST_IDLE);

  assign cmd.load = (state == ST_IDLE) && in_valid;
  assign cmd.prep = (state == ST_PREP);
  assign cmd.mul  = (state == ST_MUL);
  assign cmd.fire = (state == ST_UPD) && sts.out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = sts.need_div ? ST_DIV : ST_MUL;
      ST_DIV:  if (sts.div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
